// ===== rtl/segment_pair_intersect_test_defines.svh =====
// Assertion macros shared by the segment pair intersection test.
`ifndef SEGMENT_PAIR_INTERSECT_TEST_DEFINES_SVH
`define SEGMENT_PAIR_INTERSECT_TEST_DEFINES_SVH

// Checks that a condition in one cycle implies another in the same cycle.
`define SPIT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment pair intersect check failed in the same cycle");

// Checks that a condition in one cycle implies another in the next cycle.
`define SPIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment pair intersect check failed in the next cycle");

`endif

// ===== rtl/spit_pkg.sv =====
// Package with the shared types and constants of the segment pair intersection test.
package spit_pkg;

  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned HIT_BIT     = 0;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } spit_adv_t;

  typedef struct packed {
    logic pos;
    logic neg;
    logic in_box;
  } spit_orient_t;

endpackage

// ===== rtl/spit_orient.sv =====
// Three stage orientation and bounding box unit for one point against one segment.
module spit_orient #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk,
  input  spit_pkg::spit_adv_t           adv,
  input  logic signed [COORD_BITS-1:0]  o_x,
  input  logic signed [COORD_BITS-1:0]  o_y,
  input  logic signed [COORD_BITS-1:0]  q_x,
  input  logic signed [COORD_BITS-1:0]  q_y,
  input  logic signed [COORD_BITS-1:0]  r_x,
  input  logic signed [COORD_BITS-1:0]  r_y,
  output spit_pkg::spit_orient_t        res
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [DW-1:0] ax_nxt, ay_nxt, bx_nxt, by_nxt;
  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r;
  logic                 box_nxt, box1_r, box2_r;
  logic signed [PW-1:0] l_r, m_r;
  spit_pkg::spit_orient_t res_r;

  always_comb begin
    ax_nxt  = DW'($signed(r_x)) - DW'($signed(o_x));
    ay_nxt  = DW'($signed(r_y)) - DW'($signed(o_y));
    bx_nxt  = DW'($signed(q_x)) - DW'($signed(o_x));
    by_nxt  = DW'($signed(q_y)) - DW'($signed(o_y));
    box_nxt = ((o_x <= r_x && r_x <= q_x) || (q_x <= r_x && r_x <= o_x))
           && ((o_y <= r_y && r_y <= q_y) || (q_y <= r_y && r_y <= o_y));
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      bx_r   <= bx_nxt;
      by_r   <= by_nxt;
      box1_r <= box_nxt;
    end
    if (adv.s2) begin
      l_r    <= PW'(ax_r) * PW'(by_r);
      m_r    <= PW'(ay_r) * PW'(bx_r);
      box2_r <= box1_r;
    end
    if (adv.s3) begin
      res_r.pos    <= (l_r > m_r);
      res_r.neg    <= (l_r < m_r);
      res_r.in_box <= box2_r;
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/segment_pair_intersect_test.sv =====
// Top level of the segment pair intersection test pipeline.
//
//   channel  direction  payload
//   in_      slave      eight signed coordinates of two segments
//   out_     master     intersects flag
//
// One word is accepted per cycle while in_tready is high, that is while the pipeline can advance.
// Each result passes through the difference, multiply, compare and output register stages in order.
// Reset is synchronous and active low and clears only the valid bits.
// Each stage holds its word while the stage after it is full and cannot advance, so a stall fills bubbles first.
`include "segment_pair_intersect_test_defines.svh"

module segment_pair_intersect_test #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_BITS-1:0]            in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // intersects, then seven zero bits
  output logic [spit_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic signed [COORD_BITS-1:0] crd [8];
  spit_pkg::spit_adv_t          adv;
  spit_pkg::spit_orient_t       ori [4];
  logic v1_r, v2_r, v3_r, out_vld_r;
  logic rdy_out, hit, out_hit_r;
  logic z1, z2, z3, z4;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      crd[i] = in_tdata[i*COORD_BITS +: COORD_BITS];
    end
  end

  assign rdy_out   = !out_vld_r || out_tready;
  assign adv.s3    = !v3_r || rdy_out;
  assign adv.s2    = !v2_r || adv.s3;
  assign adv.s1    = !v1_r || adv.s2;
  assign in_tready = adv.s1;

  spit_orient #(.COORD_BITS(COORD_BITS)) u_ori1 (
    .clk(clk), .adv(adv), .o_x(crd[4]), .o_y(crd[5]), .q_x(crd[6]), .q_y(crd[7]),
    .r_x(crd[0]), .r_y(crd[1]), .res(ori[0]));
  spit_orient #(.COORD_BITS(COORD_BITS)) u_ori2 (
    .clk(clk), .adv(adv), .o_x(crd[4]), .o_y(crd[5]), .q_x(crd[6]), .q_y(crd[7]),
    .r_x(crd[2]), .r_y(crd[3]), .res(ori[1]));
  spit_orient #(.COORD_BITS(COORD_BITS)) u_ori3 (
    .clk(clk), .adv(adv), .o_x(crd[0]), .o_y(crd[1]), .q_x(crd[2]), .q_y(crd[3]),
    .r_x(crd[4]), .r_y(crd[5]), .res(ori[2]));
  spit_orient #(.COORD_BITS(COORD_BITS)) u_ori4 (
    .clk(clk), .adv(adv), .o_x(crd[0]), .o_y(crd[1]), .q_x(crd[2]), .q_y(crd[3]),
    .r_x(crd[6]), .r_y(crd[7]), .res(ori[3]));

  always_comb begin
    z1  = !ori[0].pos && !ori[0].neg;
    z2  = !ori[1].pos && !ori[1].neg;
    z3  = !ori[2].pos && !ori[2].neg;
    z4  = !ori[3].pos && !ori[3].neg;
    hit = (((ori[0].pos && ori[1].neg) || (ori[0].neg && ori[1].pos))
        && ((ori[2].pos && ori[3].neg) || (ori[2].neg && ori[3].pos)))
       || (z1 && ori[0].in_box) || (z2 && ori[1].in_box)
       || (z3 && ori[2].in_box) || (z4 && ori[3].in_box);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv.s1) begin
        v1_r <= in_tvalid;
      end
      if (adv.s2) begin
        v2_r <= v1_r;
      end
      if (adv.s3) begin
        v3_r <= v2_r;
      end
      if (rdy_out) begin
        out_vld_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_hit_r <= hit;
    end
  end

  always_comb begin
    out_tdata                   = '0;
    out_tdata[spit_pkg::HIT_BIT] = out_hit_r;
  end
  assign out_tvalid = out_vld_r;

  `SPIT_ASSERT_SAME(a_full_when_blocked, !in_tready,
    v1_r && v2_r && v3_r && out_vld_r && !out_tready)
  `SPIT_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, v1_r)
  `SPIT_ASSERT_NEXT(a_drain_empties, out_tvalid && out_tready && !v3_r, !out_tvalid)

endmodule

// ===== tb/sv/segment_pair_intersect_test_test.sv =====
// Self-checking testbench for the segment pair intersection pipeline.
module segment_pair_intersect_test_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;

  typedef logic [7:0][CW-1:0] seg_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [8*CW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [spit_pkg::OUT_TDATA_W-1:0] out_tdata;

  bit hit_expect_q[$];
  bit no_gaps = 1'b0;
  int fail_count = 0;
  int result_count = 0;
  logic [spit_pkg::OUT_TDATA_W-1:0] hit_word;

  segment_pair_intersect_test #(
    .COORD_BITS(CW)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sign of the cross product (r - o) x (q - o).
  function automatic int turn_of(longint ox, oy, qx, qy, rx, ry);
    longint l, m;
    l = (rx - ox) * (qy - oy);
    m = (ry - oy) * (qx - ox);
    return (l > m) ? 1 : ((l < m) ? -1 : 0);
  endfunction

  function automatic bit within_box(longint ox, oy, qx, qy, rx, ry);
    return ((ox < qx ? ox : qx) <= rx) && (rx <= (ox > qx ? ox : qx))
        && ((oy < qy ? oy : qy) <= ry) && (ry <= (oy > qy ? oy : qy));
  endfunction

  function automatic bit segments_meet(seg_pair_t s);
    longint px[4];
    longint py[4];
    int side[4];
    bit hit;
    for (int i = 0; i < 4; i++) begin
      px[i] = $signed(s[2*i]);
      py[i] = $signed(s[2*i+1]);
    end
    side[0] = turn_of(px[2], py[2], px[3], py[3], px[0], py[0]);
    side[1] = turn_of(px[2], py[2], px[3], py[3], px[1], py[1]);
    side[2] = turn_of(px[0], py[0], px[1], py[1], px[2], py[2]);
    side[3] = turn_of(px[0], py[0], px[1], py[1], px[3], py[3]);
    if (side[0] * side[1] < 0 && side[2] * side[3] < 0) begin
      hit = 1'b1;
    end else begin
      hit = (side[0] == 0 && within_box(px[2], py[2], px[3], py[3], px[0], py[0]))
         || (side[1] == 0 && within_box(px[2], py[2], px[3], py[3], px[1], py[1]))
         || (side[2] == 0 && within_box(px[0], py[0], px[1], py[1], px[2], py[2]))
         || (side[3] == 0 && within_box(px[0], py[0], px[1], py[1], px[3], py[3]));
    end
    return hit;
  endfunction

  function automatic seg_pair_t pair_of(int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    seg_pair_t s;
    s[0] = ax0[CW-1:0];
    s[1] = ay0[CW-1:0];
    s[2] = ax1[CW-1:0];
    s[3] = ay1[CW-1:0];
    s[4] = bx0[CW-1:0];
    s[5] = by0[CW-1:0];
    s[6] = bx1[CW-1:0];
    s[7] = by1[CW-1:0];
    return s;
  endfunction

  function automatic seg_pair_t full_range_pair();
    seg_pair_t s;
    for (int k = 0; k < 8; k++) s[k] = CW'($urandom);
    return s;
  endfunction

  function automatic seg_pair_t small_grid_pair();
    seg_pair_t s;
    int v;
    for (int k = 0; k < 8; k++) begin
      v = $urandom_range(16) - 8;
      s[k] = v[CW-1:0];
    end
    return s;
  endfunction

  // Every point is base + t*d + u*e; u == 0 puts a point on the line through base along d.
  function automatic seg_pair_t shaped_pair();
    seg_pair_t s;
    int scale, base_x, base_y, dx, dy, ex, ey, shape, j, v;
    int tt[4];
    int uu[4];
    bit [1:0] swp;
    scale = ($urandom_range(3) == 0) ? 1500 : 20;
    base_x = $urandom_range(3000) - 1500;
    base_y = $urandom_range(3000) - 1500;
    dx = $urandom_range(2 * scale) - scale;
    dy = $urandom_range(2 * scale) - scale;
    ex = $urandom_range(2 * scale) - scale;
    ey = $urandom_range(2 * scale) - scale;
    for (int i = 0; i < 4; i++) begin
      tt[i] = $urandom_range(20) - 10;
      uu[i] = $urandom_range(20) - 10;
    end
    shape = $urandom_range(5);
    case (shape)
      0: begin
        for (int i = 0; i < 4; i++) uu[i] = 0;
      end
      1: begin
        uu[0] = 0; uu[1] = 0; uu[2] = 0;
      end
      2: begin
        tt[1] = tt[0];
        uu[0] = 0; uu[1] = 0; uu[2] = 0; uu[3] = 0;
      end
      3: begin
        tt[1] = tt[0]; uu[1] = uu[0];
        if ($urandom_range(1)) begin
          tt[2] = tt[0]; uu[2] = uu[0];
        end
        tt[3] = tt[2]; uu[3] = uu[2];
      end
      4: begin
        tt[2] = tt[1]; uu[2] = uu[1];
      end
      default: begin
        tt[0] = -$urandom_range(10); tt[1] = $urandom_range(10);
        uu[0] = 0; uu[1] = 0;
        tt[2] = 0; tt[3] = 0;
        uu[2] = -$urandom_range(10); uu[3] = $urandom_range(10);
      end
    endcase
    swp = 2'($urandom_range(3));
    for (int i = 0; i < 4; i++) begin
      j = swp[i & 1] ? (i ^ 2) : i;
      v = base_x + tt[i] * dx + uu[i] * ex;
      s[2*j] = v[CW-1:0];
      v = base_y + tt[i] * dy + uu[i] * ey;
      s[2*j+1] = v[CW-1:0];
    end
    return s;
  endfunction

  function automatic seg_pair_t mixed_pair();
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) return full_range_pair();
    if (pick < 6) return small_grid_pair();
    return shaped_pair();
  endfunction

  task automatic send_pair(input seg_pair_t s);
    while (!no_gaps && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hit_expect_q = {hit_expect_q, segments_meet(s)};
  endtask

  task automatic note_failure(input string what,
                              input logic [spit_pkg::OUT_TDATA_W-1:0] want,
                              input logic [spit_pkg::OUT_TDATA_W-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("result %0d: %s, expected %h, got %h", result_count, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (hit_expect_q.size() == 0) begin
          note_failure("word with nothing expected", '0, out_tdata);
        end else begin
          hit_word = '0;
          hit_word[spit_pkg::HIT_BIT] = hit_expect_q.pop_front();
          if (out_tdata !== hit_word) note_failure("intersects mismatch", hit_word, out_tdata);
        end
        result_count++;
      end
      out_tready <= no_gaps || ($urandom_range(99) >= 14);
    end
  end

  task automatic test_directed_cases();
    send_pair(pair_of(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(pair_of(0, 0, 10, 0, 0, 1, 10, 1));
    send_pair(pair_of(0, 0, 10, 0, 5, 0, 15, 0));
    send_pair(pair_of(0, 0, 4, 0, 5, 0, 9, 0));
    send_pair(pair_of(0, 0, 5, 0, 5, 0, 9, 0));
    send_pair(pair_of(0, 0, 10, 0, 5, 0, 5, 7));
    send_pair(pair_of(0, 0, 10, 0, 5, 1, 5, 7));
    send_pair(pair_of(3, 3, 3, 3, 0, 0, 6, 6));
    send_pair(pair_of(3, 4, 3, 4, 0, 0, 6, 6));
    send_pair(pair_of(7, 7, 7, 7, 0, 0, 6, 6));
    send_pair(pair_of(2, -2, 2, -2, 2, -2, 2, -2));
    send_pair(pair_of(2, -2, 2, -2, -2, 2, -2, 2));
    send_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, -32767, 32767));
    send_pair(pair_of(-32768, 0, 32767, 0, 0, 0, 32767, 0));
    send_pair(pair_of(0, -32768, 0, -1, 0, 0, 0, 32767));
    send_pair(pair_of(-32768, -32768, -1, -1, 0, 0, 32767, 32767));
    send_pair(pair_of(0, 0, 4, 4, 6, 6, 9, 0));
    send_pair(pair_of(1, 2, 5, 9, 1, 2, -3, 4));
    send_pair(pair_of(-1, -1, 1, 1, -1, 1, 1, -1));
    send_pair(pair_of(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
  endtask

  task automatic test_full_range_random();
    repeat (300) send_pair(full_range_pair());
  endtask

  task automatic test_small_grid_random();
    repeat (250) send_pair(small_grid_pair());
  endtask

  task automatic test_constructed_geometry();
    repeat (350) send_pair(shaped_pair());
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (150) send_pair(mixed_pair());
    no_gaps = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (20) send_pair(mixed_pair());
      in_tvalid <= 1'b0;
      while (hit_expect_q.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_full_range_random();
    test_drain_pause();
    test_small_grid_random();
    test_back_to_back();
    test_constructed_geometry();
    in_tvalid <= 1'b0;
    while (hit_expect_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
